FILE: rtl/sorted_multiset_intersection_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sorted multiset intersection block
// Shared clocking and reset for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef SORTED_MULTISET_INTERSECTION_TOP_MACROS_SVH
`define SORTED_MULTISET_INTERSECTION_TOP_MACROS_SVH

// same-cycle implication
`define SMI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SMI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/smi_pkg.sv
// ----------------------------------------------------------------------------
// smi_pkg
// Types shared by the sorted multiset intersection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smi_pkg;

	localparam int VALUE_W = 64;
	localparam int POS_W   = 6;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [POS_W-1:0]          pos_t;

	// memory control between engine and store
	typedef struct packed {
		logic wr_en;
		logic wr_sel;   // 0 left, 1 right
		logic rd_en;
		logic rd_sel;
	} smi_mem_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/smi_if.sv
// ----------------------------------------------------------------------------
// smi_in_if / smi_out_if
// Valid/ready channels for list elements and intersection results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface smi_in_if;
	logic           valid;
	logic           ready;
	logic           mode;
	smi_pkg::value_t value;
	logic           last;

	modport source (output valid, output mode, output value, output last, input ready);
	modport sink   (input valid, input mode, input value, input last, output ready);
endinterface

interface smi_out_if;
	logic           valid;
	logic           ready;
	smi_pkg::value_t common_value;
	smi_pkg::pos_t  left_position;
	smi_pkg::pos_t  right_position;
	logic           none_found;
	logic           overflow;
	logic           final_res;

	modport source (output valid, output common_value, output left_position,
		output right_position, output none_found, output overflow, output final_res,
		input ready);
	modport sink   (input valid, input common_value, input left_position,
		input right_position, input none_found, input overflow, input final_res,
		output ready);
endinterface

`default_nettype wire

FILE: rtl/smi_store.sv
// ----------------------------------------------------------------------------
// smi_store
// Left and right element memories, one write and one registered read a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smi_store #(
	parameter int MAX_LEN = 64,
	parameter int AW      = $clog2(MAX_LEN)
) (
	input  logic                clk,
	input  smi_pkg::smi_mem_ctl_t ctl,
	input  logic [AW-1:0]       wr_addr,
	input  smi_pkg::value_t     wr_data,
	input  logic [AW-1:0]       rd_addr,
	output smi_pkg::value_t     rd_data
);
	import smi_pkg::*;

	value_t lmem [MAX_LEN];
	value_t rmem [MAX_LEN];
	value_t l_q;
	value_t r_q;
	logic   sel_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en && !ctl.wr_sel) begin
			lmem[wr_addr] <= wr_data;
		end
		if (ctl.wr_en && ctl.wr_sel) begin
			rmem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			l_q   <= lmem[rd_addr];
			r_q   <= rmem[rd_addr];
			sel_q <= ctl.rd_sel;
		end
	end

	assign rd_data = sel_q ? r_q : l_q;

endmodule

`default_nettype wire

FILE: rtl/smi_engine.sv
// ----------------------------------------------------------------------------
// smi_engine
// Load counters and scan sequencer: finds each next common value by
// repeated scans of the element memories with signed comparisons.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smi_engine #(
	parameter int MAX_LEN = 64,
	parameter int AW      = $clog2(MAX_LEN)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	smi_in_if.sink                items,
	smi_out_if.source             results,
	output smi_pkg::smi_mem_ctl_t ctl,
	output logic [AW-1:0]         wr_addr,
	output smi_pkg::value_t       wr_data,
	output logic [AW-1:0]         rd_addr,
	input  smi_pkg::value_t       rd_data
);
	import smi_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);
	localparam logic [CW-1:0] FULL = CW'(MAX_LEN);

	localparam logic [2:0] S_LOAD = 3'd0;
	localparam logic [2:0] S_FIND = 3'd1;
	localparam logic [2:0] S_CNTR = 3'd2;
	localparam logic [2:0] S_TAKE = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;
	localparam logic [2:0] S_NONE = 3'd5;

	logic [2:0]    st_q;
	logic [CW-1:0] lc_q, rc_q, idx_q, cl_q, cr_q, pend_cnt_q;
	logic          ovf_q, rdv_q, have_prev_q, found_q, pend_valid_q, fin_q;
	logic [AW-1:0] rda_q, lp_q, rp_q, pend_lp_q, pend_rp_q;
	value_t        prev_q, min_q, pend_val_q;

	logic          out_valid_q, out_none_q, out_ovf_q, out_fin_q;
	value_t        out_val_q;
	pos_t          out_lp_q, out_rp_q;

	logic          acc, scanning, issue, scan_end, slot_free, load_out;
	logic          gt_prev, lt_min, eq_min;
	logic [CW-1:0] scan_cnt, cmin;

	always_comb begin
		acc       = items.valid && items.ready;
		scanning  = (st_q == S_FIND) || (st_q == S_CNTR);
		scan_cnt  = (st_q == S_FIND) ? lc_q : rc_q;
		issue     = scanning && (idx_q != scan_cnt);
		scan_end  = scanning && (idx_q == scan_cnt) && !rdv_q;
		slot_free = !out_valid_q || results.ready;
		load_out  = slot_free && ((st_q == S_EMIT) || (st_q == S_NONE));
		gt_prev   = !have_prev_q || (prev_q < rd_data);
		lt_min    = rd_data < min_q;
		eq_min    = rd_data == min_q;
		cmin      = (cl_q < cr_q) ? cl_q : cr_q;

		ctl.wr_en  = acc && (items.mode ? (rc_q != FULL) : (lc_q != FULL));
		ctl.wr_sel = items.mode;
		ctl.rd_en  = issue;
		ctl.rd_sel = (st_q == S_CNTR);
		wr_addr    = items.mode ? rc_q[AW-1:0] : lc_q[AW-1:0];
		wr_data    = items.value;
		rd_addr    = idx_q[AW-1:0];
	end

	assign items.ready            = (st_q == S_LOAD);
	assign results.valid          = out_valid_q;
	assign results.common_value   = out_val_q;
	assign results.left_position  = out_lp_q;
	assign results.right_position = out_rp_q;
	assign results.none_found     = out_none_q;
	assign results.overflow       = out_ovf_q;
	assign results.final_res      = out_fin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_LOAD;
			lc_q         <= '0;
			rc_q         <= '0;
			ovf_q        <= 1'b0;
			idx_q        <= '0;
			rdv_q        <= 1'b0;
			have_prev_q  <= 1'b0;
			found_q      <= 1'b0;
			pend_valid_q <= 1'b0;
			fin_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			rdv_q <= issue;
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				S_LOAD: begin
					if (acc) begin
						if (!items.mode) begin
							if (lc_q != FULL) lc_q <= lc_q + 1'b1;
							else ovf_q <= 1'b1;
						end else begin
							if (rc_q != FULL) rc_q <= rc_q + 1'b1;
							else ovf_q <= 1'b1;
							if (items.last) begin
								st_q         <= S_FIND;
								idx_q        <= '0;
								found_q      <= 1'b0;
								have_prev_q  <= 1'b0;
								pend_valid_q <= 1'b0;
								fin_q        <= 1'b0;
							end
						end
					end
				end
				S_FIND: begin
					if (rdv_q && gt_prev) begin
						if (!found_q || lt_min) begin
							found_q <= 1'b1;
							min_q   <= rd_data;
							cl_q    <= CW'(1);
							lp_q    <= rda_q;
						end else if (eq_min) begin
							cl_q <= cl_q + 1'b1;
						end
					end
					if (scan_end) begin
						if (found_q) begin
							st_q  <= S_CNTR;
							idx_q <= '0;
							cr_q  <= '0;
						end else begin
							fin_q <= 1'b1;
							st_q  <= pend_valid_q ? S_EMIT : S_NONE;
						end
					end
				end
				S_CNTR: begin
					if (rdv_q && eq_min) begin
						if (cr_q == '0) rp_q <= rda_q;
						cr_q <= cr_q + 1'b1;
					end
					if (scan_end) begin
						if (cr_q != '0) begin
							st_q <= pend_valid_q ? S_EMIT : S_TAKE;
						end else begin
							prev_q      <= min_q;
							have_prev_q <= 1'b1;
							found_q     <= 1'b0;
							idx_q       <= '0;
							st_q        <= S_FIND;
						end
					end
				end
				S_TAKE: begin
					pend_valid_q <= 1'b1;
					pend_val_q   <= min_q;
					pend_lp_q    <= lp_q;
					pend_rp_q    <= rp_q;
					pend_cnt_q   <= cmin;
					prev_q       <= min_q;
					have_prev_q  <= 1'b1;
					found_q      <= 1'b0;
					idx_q        <= '0;
					st_q         <= S_FIND;
				end
				S_EMIT: begin
					if (slot_free) begin
						out_val_q   <= pend_val_q;
						out_lp_q    <= POS_W'(pend_lp_q);
						out_rp_q    <= POS_W'(pend_rp_q);
						out_none_q  <= 1'b0;
						out_ovf_q   <= ovf_q;
						out_fin_q   <= fin_q && (pend_cnt_q == CW'(1));
						pend_cnt_q  <= pend_cnt_q - 1'b1;
						if (pend_cnt_q == CW'(1)) begin
							if (fin_q) begin
								st_q  <= S_LOAD;
								lc_q  <= '0;
								rc_q  <= '0;
								ovf_q <= 1'b0;
							end else begin
								st_q <= S_TAKE;
							end
						end
					end
				end
				S_NONE: begin
					if (slot_free) begin
						out_val_q   <= '0;
						out_lp_q    <= '0;
						out_rp_q    <= '0;
						out_none_q  <= 1'b1;
						out_ovf_q   <= ovf_q;
						out_fin_q   <= 1'b1;
						st_q        <= S_LOAD;
						lc_q        <= '0;
						rc_q        <= '0;
						ovf_q       <= 1'b0;
					end
				end
				default: begin
					st_q <= S_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			rda_q <= idx_q[AW-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/sorted_multiset_intersection_top.sv
// ----------------------------------------------------------------------------
// sorted_multiset_intersection_top
// Multiset intersection of two loaded lists, emitted in ascending order.
//
//   channel   dir  payload
//   items     in   mode, value, last
//   results   out  common_value, left/right_position, none_found, overflow,
//                  final_res
//
// Loading accepts back-to-back transactions. A run (right element with last)
// scans the left memory once per distinct candidate plus once more, and the right
// memory once per candidate found, through the single memory read port. Reset
// clears counts and control; no memory clearing. Results stall only on the
// output register; loading is closed while a run is active.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_multiset_intersection_top #(
	parameter int MAX_LEN = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	smi_in_if.sink    items,
	smi_out_if.source results
);
	import smi_pkg::*;

	localparam int AW = $clog2(MAX_LEN);

	smi_mem_ctl_t  ctl;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;
	value_t        wr_data;
	value_t        rd_data;

	smi_engine #(.MAX_LEN(MAX_LEN), .AW(AW)) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.ctl     (ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	smi_store #(.MAX_LEN(MAX_LEN), .AW(AW)) u_store (
		.clk     (clk),
		.ctl     (ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

`default_nettype wire

FILE: rtl/smi_checker.sv
// ----------------------------------------------------------------------------
// smi_checker
// Port-level checks on the intersection block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_multiset_intersection_top_macros.svh"

module smi_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            in_mode,
	input logic            in_last,
	input logic            out_valid,
	input logic            out_ready,
	input smi_pkg::value_t out_value,
	input smi_pkg::pos_t   out_lp,
	input smi_pkg::pos_t   out_rp,
	input logic            out_none,
	input logic            out_final
);
	import smi_pkg::*;

	`SMI_ASSERT_NOW(a_none_is_final, out_valid && out_none, out_final, "none_found without final_res")
	`SMI_ASSERT_NOW(a_none_zero, out_valid && out_none, (out_value == '0) && (out_lp == '0) && (out_rp == '0), "none_found result not zero")
	`SMI_ASSERT_NEXT(a_run_closes_load, in_valid && in_ready && in_mode && in_last, !in_ready, "loading open after run start")
	`SMI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_value), "result dropped while stalled")

endmodule

bind sorted_multiset_intersection_top smi_checker u_smi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_mode   (items.mode),
	.in_last   (items.last),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_value (results.common_value),
	.out_lp    (results.left_position),
	.out_rp    (results.right_position),
	.out_none  (results.none_found),
	.out_final (results.final_res)
);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives pairs of lists into the sorted multiset intersection block and checks
// every result transaction against a behavioural predictor of the intersection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
	import smi_pkg::*;

	localparam int CAP = 64;
	localparam longint LIMIT = 3000000;

	typedef struct packed {
		value_t cv;
		pos_t   lp;
		pos_t   rp;
		logic   nf;
		logic   ov;
		logic   fin;
	} isect_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	smi_in_if  items();
	smi_out_if results();

	sorted_multiset_intersection_top #(.MAX_LEN(CAP)) dut (
		.clk(clk), .arst_n(arst_n), .items(items.sink), .results(results.source)
	);

	always #2 clk = ~clk;

	value_t left_list[CAP];
	value_t right_list[CAP];
	int     n_left = 0, n_right = 0;
	bit     cut_seen = 0;
	isect_t pending_isect[$];
	int     errors = 0, n_items = 0, n_results = 0, n_runs = 0;
	int     src_idle = 35, snk_idle = 35;
	longint cycles = 0;

	function automatic int first_at(value_t l[CAP], int n, value_t x);
		for (int i = 0; i < n; i++) if (l[i] == x) return i;
		return 0;
	endfunction

	function automatic void sort_vals(ref value_t v[$]);
		value_t t;
		for (int i = 1; i < v.size(); i++)
			for (int j = i; j > 0 && v[j] < v[j-1]; j--) begin
				t = v[j]; v[j] = v[j-1]; v[j-1] = t;
			end
	endfunction

	function automatic void predict_isect(logic mode, value_t val, logic lst);
		value_t sl[$], sr[$];
		int i, j, n;
		isect_t r;
		if (!mode) begin
			if (n_left < CAP) left_list[n_left++] = val; else cut_seen = 1;
			return;
		end
		if (n_right < CAP) right_list[n_right++] = val; else cut_seen = 1;
		if (!lst) return;
		for (int k = 0; k < n_left; k++) sl = {sl, left_list[k]};
		for (int k = 0; k < n_right; k++) sr = {sr, right_list[k]};
		sort_vals(sl);
		sort_vals(sr);
		i = 0; j = 0; n = 0;
		while (i < n_left && j < n_right && n < CAP) begin
			if (sl[i] < sr[j]) i++;
			else if (sr[j] < sl[i]) j++;
			else begin
				r = '0;
				r.cv = sl[i];
				r.lp = pos_t'(first_at(left_list, n_left, sl[i]));
				r.rp = pos_t'(first_at(right_list, n_right, sl[i]));
				r.ov = cut_seen;
				pending_isect = {pending_isect, r};
				n++; i++; j++;
			end
		end
		if (n == 0) begin
			r = '0; r.nf = 1; r.ov = cut_seen; r.fin = 1;
			pending_isect = {pending_isect, r};
		end else
			pending_isect[pending_isect.size()-1].fin = 1;
		n_left = 0; n_right = 0; cut_seen = 0; n_runs++;
	endfunction

	task automatic send_item(logic mode, value_t val, logic lst);
		while ($urandom_range(99) < src_idle) begin
			items.valid <= 0;
			@(posedge clk);
		end
		items.valid <= 1; items.mode <= mode; items.value <= val; items.last <= lst;
		do @(posedge clk); while (!items.ready);
		predict_isect(mode, val, lst);
		n_items++;
	endtask

	function automatic value_t rnd_val(int span);
		value_t v;
		if (span == 0) v = {$urandom, $urandom};
		else v = value_t'($signed($urandom_range(2 * span))) - span;
		return v;
	endfunction

	task automatic send_list(logic mode, int len, int span);
		for (int k = 0; k < len; k++) send_item(mode, rnd_val(span), k == len - 1);
	endtask

	task automatic drain;
		items.valid <= 0;
		while (pending_isect.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout at %0t", $time);
			$display("FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) results.ready <= 0;
		else results.ready <= ($urandom_range(99) >= snk_idle);
	end

	always @(posedge clk) begin
		isect_t got, exp_r;
		if (arst_n && results.valid && results.ready) begin
			got = {results.common_value, results.left_position, results.right_position,
				results.none_found, results.overflow, results.final_res};
			n_results++;
			if (pending_isect.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				exp_r = pending_isect.pop_front();
				if (got !== exp_r) begin
					$display("%0t: mismatch expected v=%0d l=%0d r=%0d nf=%b ov=%b f=%b",
						$time, exp_r.cv, exp_r.lp, exp_r.rp, exp_r.nf, exp_r.ov, exp_r.fin);
					$display("%0t:          actual   v=%0d l=%0d r=%0d nf=%b ov=%b f=%b",
						$time, got.cv, got.lp, got.rp, got.nf, got.ov, got.fin);
					errors++;
				end
			end
		end
	end

	task automatic test_extremes;
		send_item(0, 64'sh8000000000000000, 0);
		send_item(0, 64'sh7FFFFFFFFFFFFFFF, 0);
		send_item(0, 0, 0);
		send_item(0, -1, 1);
		send_item(0, -1, 0);
		send_item(1, -1, 0);
		send_item(1, 64'sh7FFFFFFFFFFFFFFF, 0);
		send_item(1, -1, 0);
		send_item(1, 64'sh8000000000000000, 1);
		send_item(0, 5, 1);
		send_item(1, 6, 1);
		send_item(1, 7, 0);
		send_item(1, 7, 1);
		send_item(0, 64'h5555555555555555, 0);
		send_item(0, 64'hAAAAAAAAAAAAAAAA, 1);
		send_item(1, 64'hAAAAAAAAAAAAAAAA, 0);
		send_item(1, 64'h5555555555555555, 1);
		drain();
	endtask

	task automatic test_overflow;
		for (int k = 0; k < CAP + 2; k++) send_item(0, k % 7, 0);
		for (int k = 0; k < CAP + 1; k++) send_item(1, k % 5, k == CAP);
		drain();
	endtask

	task automatic test_random(int budget, int idle);
		int len_l, len_r, span;
		src_idle = idle; snk_idle = idle;
		while (budget > 0) begin
			len_l = $urandom_range(6, 0);
			len_r = $urandom_range(6, 1);
			span = ($urandom_range(9) == 0) ? 0 : $urandom_range(6, 1);
			send_list(0, len_l, span);
			send_list(1, len_r, span);
			budget -= len_l + len_r;
		end
		drain();
	endtask

	initial begin
		items.valid = 0; items.mode = 0; items.value = '0; items.last = 0;
		results.ready = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_extremes();
		test_overflow();
		test_random(40, 35);
		test_random(40, 0);
		test_random(40, 35);
		$display("%0d items in %0d runs, %0d result transactions checked",
			n_items, n_runs, n_results);
		if (errors == 0 && pending_isect.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

endmodule
